[sv/sip_pkg.sv]
`timescale 1ns / 1ps
package sip_pkg;

    localparam int COORD_BITS    = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int OUT_BITS      = 32;
    localparam int DIFF_W        = COORD_BITS + 1;
    localparam int PROD_W        = 2 * DIFF_W;
    localparam int NUM_W         = PROD_W + 1;
    localparam int QDEPTH        = 4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] seg_a_start_x;
        logic signed [COORD_BITS-1:0] seg_a_start_y;
        logic signed [COORD_BITS-1:0] seg_a_end_x;
        logic signed [COORD_BITS-1:0] seg_a_end_y;
        logic signed [COORD_BITS-1:0] seg_b_start_x;
        logic signed [COORD_BITS-1:0] seg_b_start_y;
        logic signed [COORD_BITS-1:0] seg_b_end_x;
        logic signed [COORD_BITS-1:0] seg_b_end_y;
    } sip_in_t;

    typedef struct packed {
        logic                       found;
        logic signed [OUT_BITS-1:0] cross_x;
        logic signed [OUT_BITS-1:0] cross_y;
    } sip_out_t;

    // classified request handed from the front to the back
    typedef struct packed {
        logic                         found;
        logic [NUM_W-1:0]             den;
        logic [NUM_W-1:0]             tn;
        logic signed [COORD_BITS-1:0] ax0;
        logic signed [COORD_BITS-1:0] ax1;
        logic signed [COORD_BITS-1:0] ay0;
        logic signed [COORD_BITS-1:0] ay1;
    } sip_job_t;

    // registers from axis input to axis output
    function automatic int sip_lat(input int frac);
        return COORD_BITS + frac + 6;
    endfunction

endpackage

[sv/segment_intersection_point.sv]
`timescale 1ns / 1ps
// Crossing point of two line segments, one request per clock while each
// result is popped as it appears. The front forms the coordinate
// differences, their products, the determinant and the two numerators, and
// decides whether the crossing lies in both segments; a four-entry queue then
// feeds the back, where each axis runs a split multiply and a restoring
// divider that produces one quotient bit per stage (COORD_BITS + FRAC_BITS + 2
// stages). Sustained rate is one request per cycle while nothing stalls; a
// held result stops the back, and a full queue stops the front. cross_x and
// cross_y are signed fixed point with FRAC_BITS fraction bits, truncated
// toward zero, and zero when found is low.
module segment_intersection_point #(
    parameter int FRAC_BITS = sip_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  sip_pkg::sip_in_t  segments,
    output logic              empty,
    input  logic              pop,
    output sip_pkg::sip_out_t result
);
    import sip_pkg::*;

    logic     f_valid, q_full, q_empty, q_pop;
    sip_job_t f_job, q_job;

    sip_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .segments  (segments),
        .job_valid (f_valid),
        .job       (f_job),
        .job_full  (q_full)
    );

    sip_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_valid),
        .wr_data (f_job),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_job),
        .empty   (q_empty)
    );

    sip_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .job       (q_job),
        .job_pop   (q_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

    a_no_cross_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.found) |-> (result.cross_x == '0 && result.cross_y == '0))
        else $error("coordinates not zero without a crossing");

    a_full_only_on_queue: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> q_full)
        else $error("front stalled while the queue has room");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or was dropped");

endmodule

[sv/sip_front.sv]
`timescale 1ns / 1ps
module sip_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  sip_pkg::sip_in_t segments,
    output logic             job_valid,
    output sip_pkg::sip_job_t job,
    input  logic             job_full
);
    import sip_pkg::*;

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    sip_in_t p1_reg, p2_reg, p3_reg;
    logic signed [DIFF_W-1:0] rx_reg, ry_reg, sx_reg, sy_reg, wx_reg, wy_reg;
    logic signed [PROD_W-1:0] rxsy_reg, rysx_reg, wxsy_reg, wysx_reg, wxry_reg, wyrx_reg;
    logic signed [NUM_W-1:0]  den_reg, tn_reg, un_reg;
    sip_job_t job_reg, job_next;

    // hold every stage while the queue cannot take the oldest request
    assign adv       = !(v4_reg && job_full);
    assign full      = !adv;
    assign job_valid = v4_reg;
    assign job       = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= push;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= segments;
            rx_reg <= DIFF_W'(segments.seg_a_end_x) - DIFF_W'(segments.seg_a_start_x);
            ry_reg <= DIFF_W'(segments.seg_a_end_y) - DIFF_W'(segments.seg_a_start_y);
            sx_reg <= DIFF_W'(segments.seg_b_end_x) - DIFF_W'(segments.seg_b_start_x);
            sy_reg <= DIFF_W'(segments.seg_b_end_y) - DIFF_W'(segments.seg_b_start_y);
            wx_reg <= DIFF_W'(segments.seg_b_start_x) - DIFF_W'(segments.seg_a_start_x);
            wy_reg <= DIFF_W'(segments.seg_b_start_y) - DIFF_W'(segments.seg_a_start_y);

            p2_reg   <= p1_reg;
            rxsy_reg <= PROD_W'(rx_reg) * PROD_W'(sy_reg);
            rysx_reg <= PROD_W'(ry_reg) * PROD_W'(sx_reg);
            wxsy_reg <= PROD_W'(wx_reg) * PROD_W'(sy_reg);
            wysx_reg <= PROD_W'(wy_reg) * PROD_W'(sx_reg);
            wxry_reg <= PROD_W'(wx_reg) * PROD_W'(ry_reg);
            wyrx_reg <= PROD_W'(wy_reg) * PROD_W'(rx_reg);

            p3_reg  <= p2_reg;
            den_reg <= NUM_W'(rxsy_reg) - NUM_W'(rysx_reg);
            tn_reg  <= NUM_W'(wxsy_reg) - NUM_W'(wysx_reg);
            un_reg  <= NUM_W'(wxry_reg) - NUM_W'(wyrx_reg);

            job_reg <= job_next;
        end
    end

    // fold the sign of the determinant into the range test
    always_comb
    begin
        job_next     = '0;
        job_next.ax0 = p3_reg.seg_a_start_x;
        job_next.ax1 = p3_reg.seg_a_end_x;
        job_next.ay0 = p3_reg.seg_a_start_y;
        job_next.ay1 = p3_reg.seg_a_end_y;
        if (den_reg == '0)
        begin
            job_next.found = 1'b0;
            job_next.den   = '0;
            job_next.tn    = '0;
        end
        else if (den_reg < 0)
        begin
            job_next.found = (tn_reg <= 0) && (tn_reg >= den_reg) &&
                             (un_reg <= 0) && (un_reg >= den_reg);
            job_next.den   = NUM_W'(-den_reg);
            job_next.tn    = NUM_W'(-tn_reg);
        end
        else
        begin
            job_next.found = (tn_reg >= 0) && (tn_reg <= den_reg) &&
                             (un_reg >= 0) && (un_reg <= den_reg);
            job_next.den   = NUM_W'(den_reg);
            job_next.tn    = NUM_W'(tn_reg);
        end
    end

endmodule

[sv/sip_queue.sv]
`timescale 1ns / 1ps
module sip_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  sip_pkg::sip_job_t wr_data,
    output logic              full,
    input  logic              rd_en,
    output sip_pkg::sip_job_t rd_data,
    output logic              empty
);
    import sip_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    sip_job_t         mem_reg [QDEPTH];
    logic [PW-1:0]    wp_reg, rp_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CW'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= (wp_reg == PW'(QDEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (do_rd)
                rp_reg <= (rp_reg == PW'(QDEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

[sv/sip_axis.sv]
`timescale 1ns / 1ps
module sip_axis #(
    parameter int FRAC_BITS = sip_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic signed [sip_pkg::COORD_BITS-1:0]  p0,
    input  logic signed [sip_pkg::COORD_BITS-1:0]  p1,
    input  logic [sip_pkg::NUM_W-1:0]              den,
    input  logic [sip_pkg::NUM_W-1:0]              tn,
    output logic signed [sip_pkg::OUT_BITS-1:0]    value
);
    import sip_pkg::*;

    localparam int AD_W = COORD_BITS + 1;
    localparam int H    = NUM_W / 2;
    localparam int HI_W = NUM_W - H;
    localparam int PRW  = NUM_W + AD_W;
    localparam int DVW  = PRW + FRAC_BITS;
    localparam int QB   = COORD_BITS + FRAC_BITS + 2;
    localparam int RW   = NUM_W + 1;
    localparam int VW   = COORD_BITS + FRAC_BITS + 2;

    logic signed [AD_W-1:0]       d;
    logic signed [COORD_BITS-1:0] low1_reg, low2_reg;
    logic [NUM_W-1:0]             m1_reg, den1_reg, den2_reg;
    logic [AD_W-1:0]              ad1_reg;
    logic [H+AD_W-1:0]            plo_reg;
    logic [HI_W+AD_W-1:0]         phi_reg;
    logic [PRW-1:0]               prod;
    logic [DVW-1:0]               dvd;

    logic [RW-1:0]                rem_reg  [QB+1];
    logic [QB-1:0]                bits_reg [QB+1];
    logic [QB-1:0]                quo_reg  [QB+1];
    logic [NUM_W-1:0]             dd_reg   [QB+1];
    logic signed [COORD_BITS-1:0] low_reg  [QB+1];

    logic [VW-1:0]                vb, vr;
    logic signed [VW-1:0]         vs;
    logic signed [OUT_BITS-1:0]   value_reg;

    assign d    = AD_W'(p1) - AD_W'(p0);
    assign prod = (PRW'(phi_reg) << H) + PRW'(plo_reg);
    assign dvd  = DVW'(prod) << FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // descending axis: measure from the far end
            if (d < 0)
            begin
                low1_reg <= p1;
                m1_reg   <= den - tn;
                ad1_reg  <= AD_W'(-d);
            end
            else
            begin
                low1_reg <= p0;
                m1_reg   <= tn;
                ad1_reg  <= AD_W'(d);
            end
            den1_reg <= den;

            plo_reg  <= m1_reg[H-1:0] * ad1_reg;
            phi_reg  <= m1_reg[NUM_W-1:H] * ad1_reg;
            low2_reg <= low1_reg;
            den2_reg <= den1_reg;

            // quotient fits QB bits, so the top of the dividend is below den
            rem_reg[0]  <= RW'(dvd[DVW-1:QB]);
            bits_reg[0] <= dvd[QB-1:0];
            quo_reg[0]  <= '0;
            dd_reg[0]   <= den2_reg;
            low_reg[0]  <= low2_reg;
        end
    end

    for (genvar i = 0; i < QB; i++)
    begin : g_div
        logic [RW-1:0] trial;
        assign trial = {rem_reg[i][RW-2:0], bits_reg[i][QB-1]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (trial >= RW'(dd_reg[i]))
                begin
                    rem_reg[i+1] <= trial - RW'(dd_reg[i]);
                    quo_reg[i+1] <= {quo_reg[i][QB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= trial;
                    quo_reg[i+1] <= {quo_reg[i][QB-2:0], 1'b0};
                end
                bits_reg[i+1] <= bits_reg[i] << 1;
                dd_reg[i+1]   <= dd_reg[i];
                low_reg[i+1]  <= low_reg[i];
            end
        end
    end

    // round a negative result toward zero
    always_comb
    begin
        vb = (VW'(low_reg[QB]) << FRAC_BITS) + VW'(quo_reg[QB]);
        vr = (vb[VW-1] && rem_reg[QB] != '0) ? vb + 1'b1 : vb;
        vs = vr;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            value_reg <= OUT_BITS'(vs);
    end

    assign value = value_reg;

endmodule

[sv/sip_back.sv]
`timescale 1ns / 1ps
module sip_back #(
    parameter int FRAC_BITS = sip_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  sip_pkg::sip_job_t job,
    output logic              job_pop,
    output sip_pkg::sip_out_t result,
    output logic              empty,
    input  logic              pop
);
    import sip_pkg::*;

    localparam int LAT = sip_lat(FRAC_BITS);

    logic                       en;
    logic [LAT-1:0]             vld_reg;
    logic [LAT-1:0]             fnd_reg;
    logic signed [OUT_BITS-1:0] x_val, y_val;

    // advance all stages together unless the finished result is held
    assign en      = !vld_reg[LAT-1] || pop;
    assign job_pop = en && job_valid;
    assign empty   = !vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], job_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            fnd_reg <= {fnd_reg[LAT-2:0], job.found};
    end

    sip_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
        .clk   (clk),
        .en    (en),
        .p0    (job.ax0),
        .p1    (job.ax1),
        .den   (job.den),
        .tn    (job.tn),
        .value (x_val)
    );

    sip_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
        .clk   (clk),
        .en    (en),
        .p0    (job.ay0),
        .p1    (job.ay1),
        .den   (job.den),
        .tn    (job.tn),
        .value (y_val)
    );

    assign result.found   = fnd_reg[LAT-1];
    assign result.cross_x = fnd_reg[LAT-1] ? x_val : '0;
    assign result.cross_y = fnd_reg[LAT-1] ? y_val : '0;

endmodule

[dv/segment_intersection_point_tb.sv]
`timescale 1ns / 1ps
module segment_intersection_point_tb;
    import sip_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int DRAIN_CYCLES = 4 + 1 + COORD_BITS + FRAC + 6 + 20;

    logic     clk;
    logic     rst_n;
    logic     push;
    logic     full;
    sip_in_t  segments;
    logic     empty;
    logic     pop;
    sip_out_t result;

    segment_intersection_point #(.FRAC_BITS(FRAC)) dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .segments(segments),
        .empty(empty), .pop(pop), .result(result)
    );

    sip_in_t  pending_pairs[$];
    sip_out_t expected_points[$];
    int       mismatch_count;
    int       pairs_sent;
    int       points_checked;
    int       points_found;
    int       send_wait;
    int       recv_wait;
    bit       stimulus_done;
    bit       in_taken;
    bit       out_taken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // exact crossing coordinate, truncated toward zero
    function automatic logic [31:0] axis_point(longint p0, longint p1, longint tn,
                                               longint den);
        longint d;
        logic signed [127:0] num;
        logic signed [127:0] q;
        logic signed [127:0] v;
        begin
            d = p1 - p0;
            num = (128'(signed'(tn)) * 128'(signed'(d))) <<< FRAC;
            q = num / 128'(signed'(den));
            if ((num % 128'(signed'(den)) != 0) && num < 0)
                q = q - 1;  // floor of the offset
            v = (128'(signed'(p0)) <<< FRAC) + q;
            // floor, then bump negatives with remainder back toward zero
            if (v < 0 && (num % 128'(signed'(den)) != 0))
                v = v + 1;
            return v[31:0];
        end
    endfunction

    function automatic sip_out_t crossing_of(sip_in_t s);
        longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        longint rx, ry, sx, sy, wx, wy, den, tn, un;
        sip_out_t r;
        begin
            ax0 = s.seg_a_start_x; ay0 = s.seg_a_start_y;
            ax1 = s.seg_a_end_x;   ay1 = s.seg_a_end_y;
            bx0 = s.seg_b_start_x; by0 = s.seg_b_start_y;
            bx1 = s.seg_b_end_x;   by1 = s.seg_b_end_y;
            rx = ax1 - ax0; ry = ay1 - ay0;
            sx = bx1 - bx0; sy = by1 - by0;
            wx = bx0 - ax0; wy = by0 - ay0;
            den = rx * sy - ry * sx;
            tn = wx * sy - wy * sx;
            un = wx * ry - wy * rx;
            r = '0;
            if (den != 0)
            begin
                if (den < 0)
                begin
                    den = -den; tn = -tn; un = -un;
                end
                if (tn >= 0 && tn <= den && un >= 0 && un <= den)
                begin
                    r.found = 1'b1;
                    r.cross_x = axis_point(ax0, ax1, tn, den);
                    r.cross_y = axis_point(ay0, ay1, tn, den);
                end
            end
            return r;
        end
    endfunction

    function automatic logic [15:0] rand_coord(int mode);
        begin
            case (mode)
                0: return 16'(signed'($urandom_range(0, 40)) - 20);
                1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
                default: return 16'($urandom);
            endcase
        end
    endfunction

    task automatic add_pair(int ax0, int ay0, int ax1, int ay1,
                            int bx0, int by0, int bx1, int by1);
        sip_in_t s;
        begin
            s.seg_a_start_x = 16'(ax0); s.seg_a_start_y = 16'(ay0);
            s.seg_a_end_x = 16'(ax1);   s.seg_a_end_y = 16'(ay1);
            s.seg_b_start_x = 16'(bx0); s.seg_b_start_y = 16'(by0);
            s.seg_b_end_x = 16'(bx1);   s.seg_b_end_y = 16'(by1);
            pending_pairs.push_back(s);
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        begin
            $display("mismatch %s: got %h want %h (point %0d)", what, got, want,
                     points_checked);
            mismatch_count++;
        end
    endtask

    initial
    begin
        sip_in_t s;
        int mode;
        int cx, cy;
        add_pair(0, 0, 10, 10, 0, 10, 10, 0);
        add_pair(0, 0, 10, 0, 0, 5, 10, 5);
        add_pair(0, 0, 10, 0, 3, 0, 20, 0);
        add_pair(1, 1, 1, 1, 0, 0, 5, 5);
        add_pair(0, 0, 10, 0, 10, 0, 10, 10);
        add_pair(0, 0, 10, 0, 5, 0, 5, -7);
        add_pair(0, 0, 10, 0, 11, -1, 11, 1);
        add_pair(0, 0, 3, 1, 0, 1, 3, 0);
        add_pair(0, 0, -3, -1, 0, -1, -3, 0);
        add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        add_pair(32767, 32767, -32768, -32768, -32768, 32767, 32767, -32768);
        add_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
        add_pair(-32768, -32768, 32767, -32767, -32768, -32767, 32767, -32768);
        add_pair(32767, 32767, 32767, -32768, -32768, 1, 32767, 0);
        add_pair(-7, 3, 5, -11, -9, -9, 8, 7);
        add_pair(0, 0, 7, 3, 7, 3, 0, 9);
        repeat (750)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 5)
            begin
                // near crossing: segment A rises and segment B falls across a common center
                cx = $urandom_range(0, 2000) - 1000;
                cy = $urandom_range(0, 2000) - 1000;
                s.seg_a_start_x = 16'(cx - $urandom_range(0, 500));
                s.seg_a_start_y = 16'(cy - $urandom_range(0, 500));
                s.seg_a_end_x = 16'(cx + $urandom_range(0, 500));
                s.seg_a_end_y = 16'(cy + $urandom_range(0, 500));
                s.seg_b_start_x = 16'(cx - $urandom_range(0, 500));
                s.seg_b_start_y = 16'(cy + $urandom_range(0, 500));
                s.seg_b_end_x = 16'(cx + $urandom_range(0, 500));
                s.seg_b_end_y = 16'(cy - $urandom_range(0, 500));
                if ($urandom_range(0, 1)) s = {s[63:0], s[127:64]};
            end
            else
            begin
                s.seg_a_start_x = rand_coord(mode % 3);
                s.seg_a_start_y = rand_coord(mode % 3);
                s.seg_a_end_x = rand_coord(mode % 3);
                s.seg_a_end_y = rand_coord(mode % 3);
                s.seg_b_start_x = rand_coord(mode % 3);
                s.seg_b_start_y = rand_coord(mode % 3);
                s.seg_b_end_x = rand_coord(mode % 3);
                s.seg_b_end_y = rand_coord(mode % 3);
                // parallel copy of segment A, shifted
                if (mode == 9)
                begin
                    s.seg_b_start_x = s.seg_a_start_x + 16'd3;
                    s.seg_b_end_x = s.seg_a_end_x + 16'd3;
                    s.seg_b_start_y = s.seg_a_start_y;
                    s.seg_b_end_y = s.seg_a_end_y;
                end
            end
            pending_pairs.push_back(s);
        end
        stimulus_done = 1'b1;
    end

    initial
    begin
        mismatch_count = 0;
        pairs_sent = 0;
        points_checked = 0;
        points_found = 0;
        send_wait = 0;
        recv_wait = 0;
        push = 1'b0;
        pop = 1'b0;
        segments = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stimulus_done && pending_pairs.size() == 0 && !push);
        wait (expected_points.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d segment pairs, checked %0d points, %0d with a crossing",
                 pairs_sent, points_checked, points_found);
        if (mismatch_count == 0 && expected_points.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // driver: present the next request after a random gap
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!push || in_taken)
            begin
                if (send_wait > 0)
                begin
                    send_wait <= send_wait - 1;
                    push <= 1'b0;
                end
                else if (pending_pairs.size() > 0)
                begin
                    segments <= pending_pairs.pop_front();
                    push <= 1'b1;
                    send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
                end
                else
                    push <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        in_taken = rst_n && push && !full;
        if (in_taken)
        begin
            expected_points.push_back(crossing_of(segments));
            pairs_sent++;
        end
    end

    // monitor: pop with random stalls and check against the oldest prediction
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_wait > 0)
            begin
                recv_wait <= recv_wait - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                if (out_taken)
                    recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            end
        end
    end

    always @(posedge clk)
    begin
        sip_out_t want;
        out_taken = rst_n && pop && !empty;
        if (out_taken)
        begin
            if (expected_points.size() == 0)
                report_mismatch("extra result", 32'(result.found), 32'h0);
            else
            begin
                want = expected_points.pop_front();
                if (result.found !== want.found)
                    report_mismatch("found", 32'(result.found), 32'(want.found));
                if (result.cross_x !== want.cross_x)
                    report_mismatch("cross_x", result.cross_x, want.cross_x);
                if (result.cross_y !== want.cross_y)
                    report_mismatch("cross_y", result.cross_y, want.cross_y);
                if (want.found)
                    points_found++;
            end
            points_checked++;
        end
    end

    initial
    begin
        #5ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule
